>>> sv/gif_lzw_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// GIF LZW decoder assertion macros
// Assertion forms used by the decoder engine.
// ----------------------------------------------------------------------------
`ifndef GIF_LZW_DECODER_UNIT_DEFINES_SVH
`define GIF_LZW_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/gld_pkg.sv
// ----------------------------------------------------------------------------
// GIF LZW decoder package
// Word types, status codes and operation codes shared by the decoder.
// ----------------------------------------------------------------------------
package gld_pkg;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] pixel_index;
   } rsp_type;

   localparam logic [1:0] KIND_PUSH    = 2'd0;
   localparam logic [1:0] KIND_PULL    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   localparam logic [1:0] OP_PUSH    = 2'd0;
   localparam logic [1:0] OP_PULL    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;
   localparam logic [1:0] OP_NOP     = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data_byte;
   } cmd_type;

   localparam logic [2:0] ST_ACCEPTED = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_PIXEL    = 3'd2;
   localparam logic [2:0] ST_NEED     = 3'd3;
   localparam logic [2:0] ST_END      = 3'd4;
   localparam logic [2:0] ST_CORRUPT  = 3'd5;
   localparam logic [2:0] ST_RESTART  = 3'd6;

   localparam logic [1:0] FIN_RUN = 2'd0;
   localparam logic [1:0] FIN_END = 2'd1;
   localparam logic [1:0] FIN_BAD = 2'd2;

   localparam logic [3:0] ROOT_RESET = 4'd8;
   localparam logic [3:0] ROOT_MIN   = 4'd2;
   localparam logic [3:0] ROOT_MAX   = 4'd8;

endpackage

>>> sv/gld_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> sv/gld_front.sv
// ----------------------------------------------------------------------------
// GIF LZW decoder front end
// Accepts request words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module gld_front
   import gld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_pop,
   output cmd_type cmd_data
);
   cmd_type    q_ff [2];
   cmd_type    cmd_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      cmd_in.data_byte = req_data.data_byte;
      unique case (req_data.kind)
         KIND_PUSH:    cmd_in.op = OP_PUSH;
         KIND_PULL:    cmd_in.op = OP_PULL;
         KIND_RESTART: cmd_in.op = OP_RESTART;
         default:      cmd_in.op = OP_NOP;
      endcase
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end
endmodule

>>> sv/gld_engine.sv
// ----------------------------------------------------------------------------
// GIF LZW decoder engine
// Bit buffer, code table walk, output stack and the response register.
// ----------------------------------------------------------------------------
`include "gif_lzw_decoder_unit_defines.svh"
module gld_engine
   import gld_pkg::*;
#(
   parameter int MAX_CODE_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [3:0] csr_wdata,
   input  logic       cmd_valid,
   output logic       cmd_pop,
   input  cmd_type    cmd_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);
   localparam int MB = MAX_CODE_BITS;
   localparam int DEPTH = 1 << MB;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DEC  = 4'd1;
   localparam logic [3:0] S_F1   = 4'd2;
   localparam logic [3:0] S_F2   = 4'd3;
   localparam logic [3:0] S_WALK = 4'd4;
   localparam logic [3:0] S_WR   = 4'd5;
   localparam logic [3:0] S_ENT  = 4'd6;
   localparam logic [3:0] S_POP  = 4'd7;

   logic [3:0]  state_ff, state_in;
   logic [3:0]  root_ff, root_in;
   logic [23:0] buf_ff, buf_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [3:0]  width_ff, width_in;
   logic [MB:0] nfc_ff, nfc_in;
   logic [MB-1:0] prev_ff, prev_in, code_ff, code_in, walk_ff, walk_in, faddr_ff, faddr_in;
   logic        pv_ff, pv_in, kw_ff, kw_in;
   logic [MB:0] depth_ff, depth_in;
   logic [1:0]  fin_ff, fin_in;
   logic [7:0]  first_ff, first_in, fprev_ff, fprev_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [MB:0]   clr, clr1, lim;
   logic [23:0]   code24;
   logic [MB-1:0] code;
   logic [MB:0]   codex, nfc_inc;
   logic          slot_free, stk_room;
   logic [MB-1:0] tab_raddr;
   logic          tab_we, stk_we;
   logic [MB-1:0] stk_waddr, stk_raddr;
   logic [7:0]    stk_wdata, stk_rdata, suf_rdata, fst_rdata;
   logic [MB-1:0] pre_rdata;

   assign clr       = (MB+1)'(1) << root_ff;
   assign clr1      = clr + (MB+1)'(1);
   assign lim       = (MB+1)'(1) << MB;
   assign code24    = buf_ff & ((24'd1 << width_ff) - 24'd1);
   assign code      = code24[MB-1:0];
   assign codex     = {1'b0, code};
   assign nfc_inc   = nfc_ff + (MB+1)'(1);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign stk_room  = !depth_ff[MB];
   assign stk_waddr = depth_ff[MB-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   gld_ram #(.WIDTH(MB), .DEPTH(DEPTH)) u_prefix (
      .clock(clock), .wr_en(tab_we), .wr_addr(nfc_ff[MB-1:0]), .wr_data(prev_ff),
      .rd_addr(tab_raddr), .rd_data(pre_rdata));
   gld_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_suffix (
      .clock(clock), .wr_en(tab_we), .wr_addr(nfc_ff[MB-1:0]), .wr_data(first_ff),
      .rd_addr(tab_raddr), .rd_data(suf_rdata));
   gld_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_first (
      .clock(clock), .wr_en(tab_we), .wr_addr(nfc_ff[MB-1:0]), .wr_data(fprev_ff),
      .rd_addr(faddr_in), .rd_data(fst_rdata));
   gld_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata));

   always_comb begin
      state_in = state_ff;
      root_in = root_ff;
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      width_in = width_ff;
      nfc_in = nfc_ff;
      prev_in = prev_ff;
      code_in = code_ff;
      walk_in = walk_ff;
      faddr_in = faddr_ff;
      pv_in = pv_ff;
      kw_in = kw_ff;
      depth_in = depth_ff;
      fin_in = fin_ff;
      first_in = first_ff;
      fprev_in = fprev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      cmd_pop = 1'b0;
      tab_raddr = walk_ff;
      tab_we = 1'b0;
      stk_we = 1'b0;
      stk_wdata = walk_ff[7:0];
      stk_raddr = depth_ff[MB-1:0] - MB'(1);

      if (csr_we) begin
         if (csr_wdata < ROOT_MIN) begin
            root_in = ROOT_MIN;
         end else if (csr_wdata > ROOT_MAX) begin
            root_in = ROOT_MAX;
         end else begin
            root_in = csr_wdata;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               rsp_in.pixel_index = 8'd0;
               unique case (cmd_data.op)
                  OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (cnt_ff > 5'd16) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        rsp_in.status = ST_ACCEPTED;
                        buf_in = buf_ff | (24'(cmd_data.data_byte) << cnt_ff);
                        cnt_in = cnt_ff + 5'd8;
                     end
                  end
                  OP_PULL: begin
                     if (fin_ff == FIN_END) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.status = ST_END;
                     end else if (fin_ff == FIN_BAD) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.status = ST_CORRUPT;
                     end else if (depth_ff != '0) begin
                        depth_in = depth_ff - (MB+1)'(1);
                        state_in = S_POP;
                     end else begin
                        state_in = S_DEC;
                     end
                  end
                  OP_RESTART: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.status = ST_RESTART;
                     buf_in = '0;
                     cnt_in = '0;
                     prev_in = '0;
                     depth_in = '0;
                     fin_in = FIN_RUN;
                     pv_in = 1'b0;
                     width_in = root_ff + 4'd1;
                     nfc_in = clr + (MB+1)'(2);
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.status = ST_ACCEPTED;
                  end
               endcase
            end
         end
         S_DEC: begin
            rsp_in.pixel_index = 8'd0;
            if (cnt_ff < 5'(width_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = ST_NEED;
               state_in = S_IDLE;
            end else begin
               buf_in = buf_ff >> width_ff;
               cnt_in = cnt_ff - 5'(width_ff);
               code_in = code;
               priority if (codex == clr) begin
                  width_in = root_ff + 4'd1;
                  nfc_in = clr + (MB+1)'(2);
                  pv_in = 1'b0;
               end else if (codex == clr1) begin
                  fin_in = FIN_END;
                  rsp_valid_in = 1'b1;
                  rsp_in.status = ST_END;
                  state_in = S_IDLE;
               end else if (codex < clr || codex < nfc_ff) begin
                  kw_in = 1'b0;
                  faddr_in = code;
                  state_in = S_F1;
               end else if (codex == nfc_ff && pv_ff) begin
                  kw_in = 1'b1;
                  faddr_in = prev_ff;
                  state_in = S_F1;
               end else begin
                  fin_in = FIN_BAD;
                  rsp_valid_in = 1'b1;
                  rsp_in.status = ST_CORRUPT;
                  state_in = S_IDLE;
               end
            end
         end
         S_F1: begin
            first_in = ({1'b0, faddr_ff} < clr) ? faddr_ff[7:0] : fst_rdata;
            faddr_in = prev_ff;
            state_in = S_F2;
         end
         S_F2: begin
            fprev_in = ({1'b0, prev_ff} < clr) ? prev_ff[7:0] : fst_rdata;
            if (kw_ff && stk_room) begin
               stk_we = 1'b1;
               stk_wdata = first_ff;
               depth_in = depth_ff + (MB+1)'(1);
            end
            walk_in = kw_ff ? prev_ff : code_ff;
            state_in = S_WALK;
         end
         S_WALK: begin
            if ({1'b0, walk_ff} > clr1 && stk_room) begin
               state_in = S_WR;
            end else begin
               if (stk_room) begin
                  stk_we = 1'b1;
                  depth_in = depth_ff + (MB+1)'(1);
               end
               state_in = S_ENT;
            end
         end
         S_WR: begin
            stk_we = 1'b1;
            stk_wdata = suf_rdata;
            depth_in = depth_ff + (MB+1)'(1);
            walk_in = pre_rdata;
            state_in = S_WALK;
         end
         S_ENT: begin
            if (pv_ff && nfc_ff < lim) begin
               tab_we = 1'b1;
               nfc_in = nfc_inc;
               if (nfc_inc == ((MB+1)'(1) << width_ff) && width_ff < 4'(MB)) begin
                  width_in = width_ff + 4'd1;
               end
            end
            prev_in = code_ff;
            pv_in = 1'b1;
            depth_in = depth_ff - (MB+1)'(1);
            state_in = S_POP;
         end
         S_POP: begin
            rsp_valid_in = 1'b1;
            rsp_in.status = ST_PIXEL;
            rsp_in.pixel_index = stk_rdata;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         root_ff <= ROOT_RESET;
         buf_ff <= '0;
         cnt_ff <= '0;
         width_ff <= ROOT_RESET + 4'd1;
         nfc_ff <= ((MB+1)'(1) << ROOT_RESET) + (MB+1)'(2);
         prev_ff <= '0;
         pv_ff <= 1'b0;
         depth_ff <= '0;
         fin_ff <= FIN_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         root_ff <= root_in;
         buf_ff <= buf_in;
         cnt_ff <= cnt_in;
         width_ff <= width_in;
         nfc_ff <= nfc_in;
         prev_ff <= prev_in;
         pv_ff <= pv_in;
         depth_ff <= depth_in;
         fin_ff <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff <= code_in;
      walk_ff <= walk_in;
      faddr_ff <= faddr_in;
      kw_ff <= kw_in;
      first_ff <= first_in;
      fprev_ff <= fprev_in;
      rsp_ff <= rsp_in;
   end

   `GLD_ASSERT_NOW(a_width_cap, clock, reset, 1'b1, width_ff <= 4'(MB), "code width above cap")
   `GLD_ASSERT_NOW(a_table_cap, clock, reset, 1'b1, nfc_ff <= lim, "table beyond its depth")
   `GLD_ASSERT_NOW(a_busy_slot, clock, reset, state_ff != S_IDLE, !rsp_valid_ff,
      "response pending while a pull is in progress")
   `GLD_ASSERT_NEXT(a_pop_pixel, clock, reset, state_ff == S_POP,
      rsp_valid_ff && rsp_ff.status == ST_PIXEL, "pop gave no pixel")
endmodule

>>> sv/gif_lzw_decoder_unit.sv
// ----------------------------------------------------------------------------
// GIF LZW decoder unit
// Push/pull LZW decompressor for GIF image data.
//
//   Channel  Direction  Word
//   req_     in         kind, data_byte
//   rsp_     out        status, pixel_index
//   csr_     in         root code size, write only
//
// A push, restart or finished pull is answered from the idle state, a pixel
// from a filled stack from the pop state, and a pull that ends short of bits
// or at an end or bad code from the decode state. A decoding pull passes the
// decode, first-byte fetch, walk, entry and pop states, with a walk and write
// step per table entry on its prefix chain and a decode step per clear code,
// since the prefix and suffix memories are read once per step.
// Reset is synchronous; the table memories need no clearing pass.
// A two-word queue lets requests arrive while the engine or response waits.
// ----------------------------------------------------------------------------
module gif_lzw_decoder_unit
   import gld_pkg::*;
#(
   parameter int MAX_CODE_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [3:0] csr_wdata
);
   logic    cmd_valid, cmd_pop;
   cmd_type cmd_data;

   gld_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd_data(cmd_data));

   gld_engine #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_engine (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd_data(cmd_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));
endmodule

>>> tb/tb_gif_lzw_decoder_unit.sv
// ----------------------------------------------------------------------------
// GIF LZW decoder unit testbench
// Drives push, pull and restart words into the decoder with random bursts and
// response stalls, predicts every status and pixel with a behavioural LZW
// decoder held in the testbench, and compares each response word in order.
// ----------------------------------------------------------------------------
module tb_gif_lzw_decoder_unit;
   import gld_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_we;
   logic [3:0] csr_wdata;

   gif_lzw_decoder_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // Decoder state kept by the predictor.
   int unsigned root_bits, live_root;
   int unsigned bit_buf, bit_cnt, width, next_code, last_code, depth, fin;
   bit          prev_ok;
   logic [11:0] prefix_mem [4096];
   logic [7:0]  suffix_mem [4096];
   logic [7:0]  first_mem [4096];
   logic [7:0]  stack_mem [4096];

   rsp_type     expected_words[$];
   int          errors, word_count, pixel_count, stall_mode;
   bit          burst_on;
   int          burst_left;

   // Symbols built by the encoder side for well-formed streams.
   int unsigned enc_buf, enc_cnt;
   byte unsigned stream_bytes[$];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("FAIL");
      $finish;
   end

   function automatic int unsigned clear_code();
      return 1 << live_root;
   endfunction

   function automatic void table_reset();
      next_code = clear_code() + 2;
      width = live_root + 1;
      prev_ok = 0;
   endfunction

   function automatic void restart_model();
      live_root = root_bits;
      bit_buf = 0; bit_cnt = 0; last_code = 0; depth = 0; fin = FIN_RUN;
      table_reset();
   endfunction

   function automatic int unsigned first_of(int unsigned c);
      return c < clear_code() ? c : first_mem[c % 4096];
   endfunction

   function automatic void stack_push(int unsigned v);
      if (depth < 4096) begin
         stack_mem[depth] = v[7:0];
         depth++;
      end
   endfunction

   function automatic void stack_string(int unsigned c);
      while (c > clear_code() + 1 && c < 4096 && depth < 4096) begin
         stack_push(suffix_mem[c]);
         c = prefix_mem[c];
      end
      stack_push(c & 8'hff);
   endfunction

   function automatic logic [2:0] decode_pull(output logic [7:0] pix);
      int unsigned code, first, clr;
      clr = clear_code();
      pix = 0;
      if (fin == FIN_END) return ST_END;
      if (fin == FIN_BAD) return ST_CORRUPT;
      forever begin
         if (depth > 0) begin
            depth--;
            pix = stack_mem[depth];
            return ST_PIXEL;
         end
         if (bit_cnt < width) return ST_NEED;
         code = bit_buf & ((1 << width) - 1);
         bit_buf >>= width;
         bit_cnt -= width;
         if (code == clr) begin
            table_reset();
            continue;
         end
         if (code == clr + 1) begin
            fin = FIN_END;
            return ST_END;
         end
         if (code < clr || (code > clr + 1 && code < next_code)) begin
            first = first_of(code);
            stack_string(code);
         end else if (code == next_code && prev_ok) begin
            first = first_of(last_code);
            stack_push(first);
            stack_string(last_code);
         end else begin
            fin = FIN_BAD;
            return ST_CORRUPT;
         end
         if (prev_ok && next_code < 4096) begin
            prefix_mem[next_code] = last_code[11:0];
            suffix_mem[next_code] = first[7:0];
            first_mem[next_code] = 8'(first_of(last_code));
            next_code++;
            if (next_code == (1 << width) && width < 12) width++;
         end
         last_code = code;
         prev_ok = 1;
      end
   endfunction

   function automatic rsp_type predict_word(req_type w);
      rsp_type r;
      logic [7:0] pix;
      r.status = ST_ACCEPTED;
      r.pixel_index = 0;
      case (w.kind)
         KIND_PUSH: begin
            if (bit_cnt > 16) r.status = ST_FULL;
            else begin
               bit_buf = (bit_buf | (w.data_byte << bit_cnt)) & 24'hffffff;
               bit_cnt += 8;
            end
         end
         KIND_PULL: begin
            r.status = decode_pull(pix);
            if (r.status == ST_PIXEL) r.pixel_index = pix;
         end
         KIND_RESTART: begin
            restart_model();
            r.status = ST_RESTART;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_word(input logic [1:0] kind, input logic [7:0] data);
      req_type w;
      int gap;
      w.kind = kind;
      w.data_byte = data;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_words.insert(expected_words.size(), predict_word(w));
      word_count++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_root(input logic [3:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      root_bits = v < 2 ? 2 : (v > 8 ? 8 : v);
      live_root = root_bits;
   endtask

   // Response checker.
   always @(posedge clock) begin
      rsp_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word %h", $time, rsp_data);
            errors++;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_data.status != exp_w.status)
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_w.status, rsp_data.status);
            if (rsp_data.pixel_index != exp_w.pixel_index)
               $display("%0t: pixel expected %0d actual %0d", $time,
                        exp_w.pixel_index, rsp_data.pixel_index);
            if (rsp_data != exp_w) errors++;
            if (exp_w.status == ST_PIXEL) pixel_count++;
         end
      end
   end

   always @(posedge clock) begin
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 1) != 0);
      endcase
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
   end

   // Encoder helpers building byte streams from code sequences.
   function automatic void emit_code(int unsigned c, int unsigned w);
      enc_buf |= c << enc_cnt;
      enc_cnt += w;
      while (enc_cnt >= 8) begin
         stream_bytes.insert(stream_bytes.size(), enc_buf[7:0]);
         enc_buf >>= 8;
         enc_cnt -= 8;
      end
   endfunction

   // Builds a valid stream of n codes with random content and occasional
   // clears and repeats of the newest entry, mirroring the decoder's width.
   function automatic void build_stream(int unsigned root, int n, bit ended);
      int unsigned clr, nxt, w, c;
      bit have_prev;
      clr = 1 << root;
      enc_buf = 0; enc_cnt = 0;
      stream_bytes.delete();
      w = root + 1; nxt = clr + 2; have_prev = 0;
      emit_code(clr, w);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 40) == 0) begin
            emit_code(clr, w);
            w = root + 1; nxt = clr + 2; have_prev = 0;
            continue;
         end
         if (have_prev && $urandom_range(0, 5) == 0) c = nxt;
         else if (nxt > clr + 2 && $urandom_range(0, 1)) c = $urandom_range(clr + 2, nxt - 1);
         else c = $urandom_range(0, clr - 1);
         emit_code(c, w);
         if (have_prev && nxt < 4096) begin
            nxt++;
            if (nxt == (1 << w) && w < 12) w++;
         end
         have_prev = 1;
      end
      if (ended) emit_code(clr + 1, w);
      if (enc_cnt > 0) stream_bytes.insert(stream_bytes.size(), enc_buf[7:0]);
   endfunction

   // Interleaves pushes with enough pulls to keep the buffer moving.
   task automatic play_stream();
      int pulls;
      send_word(KIND_RESTART, 8'd0);
      foreach (stream_bytes[i]) begin
         send_word(KIND_PUSH, stream_bytes[i]);
         pulls = $urandom_range(0, 4);
         repeat (pulls) send_word(KIND_PULL, 8'd0);
      end
      repeat ($urandom_range(2, 10)) send_word(KIND_PULL, 8'd0);
   endtask

   task automatic test_directed();
      send_word(KIND_PULL, 8'd0);
      send_word(KIND_PUSH, 8'h00);
      send_word(KIND_PUSH, 8'hff);
      send_word(KIND_PUSH, 8'h55);
      send_word(KIND_PUSH, 8'haa);
      send_word(2'd3, 8'h3c);
      send_word(KIND_PULL, 8'd0);
      send_word(KIND_PULL, 8'd0);
      send_word(KIND_RESTART, 8'd0);
      // Clear and literal 7 at nine bits, a push refused as full, then literal 129.
      send_word(KIND_PUSH, 8'h00);
      send_word(KIND_PUSH, 8'h0f);
      send_word(KIND_PUSH, 8'h04);
      send_word(KIND_PUSH, 8'h08);
      repeat (3) send_word(KIND_PULL, 8'd0);
      send_word(KIND_PUSH, 8'h12);
      send_word(KIND_PULL, 8'd0);
      send_word(KIND_RESTART, 8'd0);
      // Code above the next free code gives corrupt, which then sticks.
      send_word(KIND_PUSH, 8'hff);
      send_word(KIND_PUSH, 8'hff);
      send_word(KIND_PULL, 8'd0);
      send_word(KIND_PULL, 8'd0);
      send_word(KIND_RESTART, 8'd0);
   endtask

   task automatic test_streams(input int unsigned root, input int count);
      write_root(root[3:0]);
      send_word(KIND_RESTART, 8'd0);
      for (int s = 0; s < count; s++) begin
         build_stream(root_bits, $urandom_range(3, 30), $urandom_range(0, 3) != 0);
         play_stream();
      end
   endtask

   task automatic test_noise(input int n);
      for (int i = 0; i < n; i++)
         case ($urandom_range(0, 9))
            0: send_word(KIND_RESTART, 8'($urandom));
            1: send_word(2'd3, 8'($urandom));
            2, 3, 4: send_word(KIND_PUSH, 8'($urandom));
            default: send_word(KIND_PULL, 8'($urandom));
         endcase
   endtask

   task automatic test_long_table();
      // Longer run at the smallest code size grows the code width several times.
      write_root(4'd2);
      build_stream(2, 60, 1);
      send_word(KIND_RESTART, 8'd0);
      foreach (stream_bytes[i]) begin
         send_word(KIND_PUSH, stream_bytes[i]);
         repeat (3) send_word(KIND_PULL, 8'd0);
      end
      repeat (40) send_word(KIND_PULL, 8'd0);
   endtask

   initial begin
      errors = 0; word_count = 0; pixel_count = 0; stall_mode = 0;
      burst_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = 4'd0;
      root_bits = ROOT_RESET;
      restart_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_streams(8, 1);
      test_streams(2, 2);
      test_streams(0, 1);
      test_streams(15, 1);
      test_streams(5, 2);
      test_noise(60);
      test_long_table();
      test_streams(8, 1);
      drain();
      $display("Sent %0d words across code sizes 2 to 8, %0d pixels checked.",
               word_count, pixel_count);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/gld_pkg.sv
sv/gld_ram.sv
sv/gld_front.sv
sv/gld_engine.sv
sv/gif_lzw_decoder_unit.sv
tb/tb_gif_lzw_decoder_unit.sv
